[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/ebur_pkg.sv]
// Types and constants of the Burmann error function pipeline.
`timescale 1ns / 1ps
package ebur_pkg;
   localparam int SERIES_TERMS = 12;
   localparam int SQRT_STEPS = 29;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [29:0] K1_Q32 = 30'd751184501;
   localparam logic [27:0] K2_Q32 = 28'd206575738;
   localparam logic [16:0] MAG_MAX = 17'd32767;
   localparam logic [7:0] SHIFT_MAX = 8'd32;

   typedef struct packed {
      logic [31:0] g;
      logic [32:0] p;
      logic [7:0]  n;
   } ebur_lane_type;

   typedef struct packed {
      logic                valid;
      logic                neg;
      ebur_lane_type [1:0] lane;
   } ebur_cell_type;

   typedef struct packed {
      logic        valid;
      logic        neg;
      logic [32:0] f;
   } ebur_side_type;
endpackage

[hw/rtl/ebur_cell.sv]
// One Horner step of exp(-g) for both exponential lanes: p = 1 - (g*p)/K.
`timescale 1ns / 1ps
module ebur_cell import ebur_pkg::*; #(
   parameter int K = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  ebur_cell_type cell_in,
   output ebur_cell_type cell_out
);
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
   localparam logic [3:0]  KV = 4'(K);

   ebur_cell_type s1_ff, s2_ff, s3_ff;
   logic [31:0] h1_ff [2];
   logic [31:0] h2_ff [2];
   logic [31:0] q2_ff [2];
   logic [64:0] mul_gp [2];
   logic [64:0] mul_rc [2];
   logic [35:0] rem [2];
   logic [31:0] quo [2];
   ebur_cell_type s3_in;

   always_comb begin
      s3_in = s2_ff;
      for (int l = 0; l < 2; l++) begin
         mul_gp[l] = {33'd0, cell_in.lane[l].g} * {32'd0, cell_in.lane[l].p};
         mul_rc[l] = {33'd0, h1_ff[l]} * {32'd0, RECIP};
         rem[l] = {4'd0, h2_ff[l]} - ({4'd0, q2_ff[l]} * {32'd0, KV});
         quo[l] = (rem[l] >= {32'd0, KV}) ? q2_ff[l] + 32'd1 : q2_ff[l];
         s3_in.lane[l].p = ONE_Q32 - {1'b0, quo[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff <= cell_in;
         s2_ff <= s1_ff;
         s3_ff <= s3_in;
         for (int l = 0; l < 2; l++) begin
            h1_ff[l] <= mul_gp[l][63:32];
            h2_ff[l] <= h1_ff[l];
            q2_ff[l] <= mul_rc[l][63:32];
         end
      end
   end

   assign cell_out = s3_ff;
endmodule

[hw/rtl/ebur_sqrt.sv]
// Pipelined bit-by-bit integer square root, one result bit per stage.
`timescale 1ns / 1ps
module ebur_sqrt import ebur_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [56:0]   v_in,
   input  ebur_side_type side_in,
   output logic [28:0]   root,
   output ebur_side_type side_out
);
   logic [56:0]   v_ff   [SQRT_STEPS];
   logic [56:0]   res_ff [SQRT_STEPS];
   ebur_side_type side_ff [SQRT_STEPS];
   logic [56:0]   v_cur  [SQRT_STEPS];
   logic [56:0]   res_cur [SQRT_STEPS];
   logic [56:0]   v_in_s [SQRT_STEPS];
   logic [56:0]   res_in [SQRT_STEPS];
   ebur_side_type side_cur [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [56:0] BITV = 57'd1 << (2 * (SQRT_STEPS - 1 - j));
      logic [56:0] trial;
      if (j == 0) begin : g_first
         assign v_cur[j] = v_in;
         assign res_cur[j] = '0;
         assign side_cur[j] = side_in;
      end else begin : g_rest
         assign v_cur[j] = v_ff[j-1];
         assign res_cur[j] = res_ff[j-1];
         assign side_cur[j] = side_ff[j-1];
      end
      always_comb begin
         trial = res_cur[j] + BITV;
         if (v_cur[j] >= trial) begin
            v_in_s[j] = v_cur[j] - trial;
            res_in[j] = (res_cur[j] >> 1) + BITV;
         end else begin
            v_in_s[j] = v_cur[j];
            res_in[j] = res_cur[j] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j].valid <= 1'b0;
         end else if (en) begin
            side_ff[j] <= side_cur[j];
            v_ff[j] <= v_in_s[j];
            res_ff[j] <= res_in[j];
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][28:0];
   assign side_out = side_ff[SQRT_STEPS-1];
endmodule

[hw/rtl/erf_burmann_approx.sv]
// Top level of the fixed-point Burmann error function pipeline.
// Usage: present x (signed Q3.12) on req_x_value with req_valid; the word is taken
// when req_valid and req_ready are both high. Each word gives one rsp_erf_value
// (signed Q1.15, magnitude saturated to 32767) on the rsp_ handshake.
// The pipeline has 73 register stages: 4 front stages, 12 Horner cells of 3 stages
// each, 2 stages forming e and the root operand, 29 square root stages and 2 output
// stages. One word is taken per cycle while the pipeline is not held.
// The whole pipeline advances together; it holds when the output register is
// full and rsp_ready is low, and req_ready drops for that cycle.
// Reset clears every stage valid bit; data registers are not reset.
// The block keeps no state between words.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module erf_burmann_approx import ebur_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_x_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_erf_value
);
   logic en;
   logic v0_ff, v1_ff, v2_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic n0_ff, n1_ff, n2_ff, n4_ff, n5_ff, n6_ff;
   logic [16:0] a_ff, a_in;
   logic [30:0] t_ff;
   logic [38:0] u_ff;
   logic [61:0] mul_u;
   logic [63:0] mul_g1, mul_g2;
   logic [31:0] f2;
   ebur_cell_type c0_ff, c0_in;
   ebur_cell_type chain [SERIES_TERMS+1];
   logic [32:0] e_ff, e2_ff, e_in, e2_in;
   logic [56:0] v_ff;
   logic [30:0] kp1_ff;
   logic [28:0] kp2_ff;
   logic [62:0] mul_k1;
   logic [60:0] mul_k2;
   ebur_side_type sq_side_in, sq_side;
   logic [28:0] root;
   logic [61:0] prod_ff;
   logic [61:0] rnd;
   logic [16:0] mag;
   logic [15:0] out_ff, out_in;

   assign en = !v7_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = v7_ff;
   assign rsp_erf_value = out_ff;

   assign a_in = req_x_value[15] ? (17'h10000 - {1'b0, req_x_value}) : {1'b0, req_x_value};
   assign mul_u = {31'd0, t_ff} * {31'd0, LOG2E_Q30};
   assign f2 = {u_ff[30:0], 1'b0};
   assign mul_g1 = {32'd0, u_ff[31:0]} * {32'd0, LN2_Q32};
   assign mul_g2 = {32'd0, f2} * {32'd0, LN2_Q32};

   always_comb begin
      c0_in.valid = v2_ff;
      c0_in.neg = n2_ff;
      c0_in.lane[0].g = mul_g1[63:32];
      c0_in.lane[0].p = ONE_Q32;
      c0_in.lane[0].n = {1'b0, u_ff[38:32]};
      c0_in.lane[1].g = mul_g2[63:32];
      c0_in.lane[1].p = ONE_Q32;
      c0_in.lane[1].n = u_ff[38:31];
   end

   assign chain[0] = c0_ff;
   for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_cell
      ebur_cell #(.K(SERIES_TERMS - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign e_in = (chain[SERIES_TERMS].lane[0].n > SHIFT_MAX) ? '0 :
                 chain[SERIES_TERMS].lane[0].p >> chain[SERIES_TERMS].lane[0].n[5:0];
   assign e2_in = (chain[SERIES_TERMS].lane[1].n > SHIFT_MAX) ? '0 :
                  chain[SERIES_TERMS].lane[1].p >> chain[SERIES_TERMS].lane[1].n[5:0];

   assign mul_k1 = {33'd0, K1_Q32} * {30'd0, e_ff};
   assign mul_k2 = {33'd0, K2_Q32} * {28'd0, e2_ff};

   always_comb begin
      sq_side_in.valid = v5_ff;
      sq_side_in.neg = n5_ff;
      sq_side_in.f = ONE_Q32 + {2'b0, kp1_ff} - {4'b0, kp2_ff};
   end

   ebur_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .v_in     (v_ff),
      .side_in  (sq_side_in),
      .root     (root),
      .side_out (sq_side)
   );

   assign rnd = prod_ff + (62'd1 << 44);
   assign mag = (rnd[61:45] > MAG_MAX) ? MAG_MAX : rnd[61:45];
   assign out_in = n6_ff ? 16'(17'h10000 - mag) : mag[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         c0_ff.valid <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         n0_ff <= req_x_value[15];
         a_ff <= a_in;
         v1_ff <= v0_ff;
         n1_ff <= n0_ff;
         t_ff <= 31'({17'd0, a_ff} * {17'd0, a_ff});
         v2_ff <= v1_ff;
         n2_ff <= n1_ff;
         u_ff <= mul_u[60:22];
         c0_ff <= c0_in;
         v4_ff <= chain[SERIES_TERMS].valid;
         n4_ff <= chain[SERIES_TERMS].neg;
         e_ff <= e_in;
         e2_ff <= e2_in;
         v5_ff <= v4_ff;
         n5_ff <= n4_ff;
         v_ff <= {ONE_Q32 - e_ff, 24'd0};
         kp1_ff <= mul_k1[62:32];
         kp2_ff <= mul_k2[60:32];
         v6_ff <= sq_side.valid;
         n6_ff <= sq_side.neg;
         prod_ff <= {33'd0, root} * {29'd0, sq_side.f};
         v7_ff <= v6_ff;
         out_ff <= out_in;
      end
   end

   `ASSERT_IMP(a_no_min_out, clock, reset, rsp_valid, rsp_erf_value != 16'h8000)
   `ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, $stable(sq_side.valid))
   `ASSERT_IMP(a_exp_range, clock, reset, v4_ff, (e_ff <= ONE_Q32) && (e2_ff <= ONE_Q32))
endmodule

[verif/erf_burmann_approx_test.sv]
// Testbench for the Burmann error function pipeline: checks each result against a model.
`timescale 1ns / 1ps
module erf_burmann_approx_test;

   localparam int LATENCY = 73;
   localparam int RANDOM_WORDS = 600;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [15:0] x;
      logic        known;
      logic [15:0] erf;
   } erf_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_x_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_erf_value;

   logic [15:0] erf_due[$];
   int          errors = 0;
   longint      cycles = 0;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off;
   bit          hold_req;
   bit          hold_started;
   int          phase_pct [4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{31, 31}};

   erf_burmann_approx dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_x_value(req_x_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_erf_value(rsp_erf_value)
   );

   function automatic logic [63:0] neg_exp2(input logic [63:0] v);
      logic [63:0] n;
      logic [63:0] g;
      logic [63:0] p;
      n = v >> 32;
      g = ((v & 64'hFFFF_FFFF) * 64'd2977044472) >> 32;
      p = 64'h1_0000_0000;
      for (int k = 12; k >= 1; k--)
         p = 64'h1_0000_0000 - (((g * p) >> 32) / k);
      if (n > 32)
         return 0;
      return p >> n;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'h1 << 62;
      while (b > v)
         b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] erf_of(input logic [15:0] x);
      logic [63:0] a;
      logic [63:0] u;
      logic [63:0] e;
      logic [63:0] e2;
      logic [63:0] r;
      logic [63:0] f;
      logic [63:0] m;
      a = x[15] ? 64'h10000 - x : x;
      u = ((a * a) * 64'd1549082005) >> 22;
      e = neg_exp2(u);
      e2 = neg_exp2(u << 1);
      r = root_floor((64'h1_0000_0000 - e) << 24);
      f = 64'h1_0000_0000 + ((64'd751184501 * e) >> 32) - ((64'd206575738 * e2) >> 32);
      m = (r * f + (64'h1 << 44)) >> 45;
      if (m > 32767)
         m = 32767;
      return x[15] ? 16'(17'h10000 - m) : m[15:0];
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_off <= 0;
         hold_started <= 0;
      end else if (hold_req && !hold_started) begin
         rsp_ready <= 0;
         hold_off <= 300;
         hold_started <= 1;
      end else if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (erf_due.size() == 0) begin
            $display("%0t: unexpected word, actual %0d", $realtime, $signed(rsp_erf_value));
            errors++;
         end else begin
            if (erf_due[0] !== rsp_erf_value) begin
               $display("%0t: erf mismatch, expected %0d actual %0d", $realtime,
                  $signed(erf_due[0]), $signed(rsp_erf_value));
               errors++;
            end
            void'(erf_due.pop_front());
         end
      end
   end

   task automatic send_word(input logic [15:0] x, input logic known, input logic [15:0] erf);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_x_value <= x;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      erf_due.push_back(known ? erf : erf_of(x));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (erf_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [15:0] random_x();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(4096)) - 2048);
         2: return 16'($signed($urandom_range(16384)) - 8192);
         default: return 16'($signed($urandom_range(24576)) - 12288);
      endcase
   endfunction

   erf_row_type directed [20] = '{
      '{16'h0000, 1, 16'h0000},
      '{16'h8000, 1, 16'h8001},
      '{16'h7FFF, 1, 16'h7FFF},
      '{16'h8001, 1, 16'h8001},
      '{16'h4000, 1, 16'h7FFF},
      '{16'hC000, 1, 16'h8001},
      '{16'h0001, 0, 0}, '{16'hFFFF, 0, 0},
      '{16'h1000, 0, 0}, '{16'hF000, 0, 0},
      '{16'h0800, 0, 0}, '{16'hF800, 0, 0},
      '{16'h2000, 0, 0}, '{16'hE000, 0, 0},
      '{16'h0100, 0, 0}, '{16'h3000, 0, 0},
      '{16'h5555, 0, 0}, '{16'hAAAA, 0, 0},
      '{16'h00FF, 0, 0}, '{16'h1800, 0, 0}
   };

   initial begin
      hold_req = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      req_valid = 0;
      req_x_value = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      foreach (directed[i])
         send_word(directed[i].x, directed[i].known, directed[i].erf);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_pct[ph][0];
         recv_stall_pct = phase_pct[ph][1];
         for (int i = 0; i < RANDOM_WORDS / 4; i++)
            send_word(random_x(), 0, 0);
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1;
      for (int i = 0; i < 120; i++)
         send_word(random_x(), 0, 0);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && erf_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
